// ===== hdl/cau_pkg.sv =====
// Shared types and constants for the complex arithmetic unit.
package cau_pkg;

	localparam int FRAC_BITS_DEF = 8;
	localparam int PART_W = 16;
	localparam int VAL_W = 34;
	localparam int REM_W = 48;
	localparam int Q_W = 16;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_DZ  = 2'd2;

	typedef struct packed {
		logic [1:0]              op;
		logic                    neg_r;
		logic                    neg_i;
		logic                    dz;
		logic                    esat_r;
		logic                    esat_i;
		logic signed [VAL_W-1:0] val_r;
		logic signed [VAL_W-1:0] val_i;
	} side_t;

endpackage

// ===== hdl/cau_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage for both parts.
module cau_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_vld,
	input  cau_pkg::side_t            in_side,
	input  logic [cau_pkg::REM_W-1:0] in_mag_r,
	input  logic [cau_pkg::REM_W-1:0] in_mag_i,
	input  logic [31:0]               in_den,
	output logic                      out_vld,
	output cau_pkg::side_t            out_side,
	output logic [cau_pkg::Q_W-1:0]   out_q_r,
	output logic [cau_pkg::Q_W-1:0]   out_q_i
);
	localparam int N = cau_pkg::Q_W;

	logic                      vld_sk  [0:N];
	cau_pkg::side_t            side_sk [0:N];
	logic [cau_pkg::REM_W-1:0] rem_r_sk[0:N];
	logic [cau_pkg::REM_W-1:0] rem_i_sk[0:N];
	logic [31:0]               den_sk  [0:N];
	logic [N-1:0]              q_r_sk  [0:N];
	logic [N-1:0]              q_i_sk  [0:N];

	assign vld_sk[0]   = in_vld;
	assign side_sk[0]  = in_side;
	assign rem_r_sk[0] = in_mag_r;
	assign rem_i_sk[0] = in_mag_i;
	assign den_sk[0]   = in_den;
	assign q_r_sk[0]   = '0;
	assign q_i_sk[0]   = '0;

	genvar i;
	generate
		for (i = 0; i < N; i++) begin : g_stage
			logic [cau_pkg::REM_W-1:0] dsh;
			logic                      ge_r, ge_i;
			assign dsh  = cau_pkg::REM_W'(den_sk[i]) << (N - 1 - i);
			assign ge_r = rem_r_sk[i] >= dsh;
			assign ge_i = rem_i_sk[i] >= dsh;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_sk[i+1] <= 1'b0;
				end else begin
					vld_sk[i+1] <= vld_sk[i];
				end
			end

			always_ff @(posedge clk) begin
				side_sk[i+1]  <= side_sk[i];
				den_sk[i+1]   <= den_sk[i];
				rem_r_sk[i+1] <= ge_r ? rem_r_sk[i] - dsh : rem_r_sk[i];
				rem_i_sk[i+1] <= ge_i ? rem_i_sk[i] - dsh : rem_i_sk[i];
				q_r_sk[i+1]   <= q_r_sk[i] | (N'(ge_r) << (N - 1 - i));
				q_i_sk[i+1]   <= q_i_sk[i] | (N'(ge_i) << (N - 1 - i));
			end
		end
	endgenerate

	assign out_vld  = vld_sk[N];
	assign out_side = side_sk[N];
	assign out_q_r  = q_r_sk[N];
	assign out_q_i  = q_i_sk[N];
endmodule

// ===== hdl/complex_arithmetic_unit.sv =====
// Top level of the complex arithmetic unit.
// Fully pipelined: one request may be issued every cycle (busy stays low) and each result
// appears on done after passing through three arithmetic stages, the 16-stage quotient
// pipeline and the output register. Results cannot be held off by the receiver; they
// are shown for one cycle only.
module complex_arithmetic_unit #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          opcode,
	input  logic signed [15:0]  a_real,
	input  logic signed [15:0]  a_imag,
	input  logic signed [15:0]  b_real,
	input  logic signed [15:0]  b_imag,
	output logic                done,
	output logic signed [15:0]  res_real,
	output logic signed [15:0]  res_imag,
	output logic [1:0]          status
);
	localparam int VW = cau_pkg::VAL_W;
	localparam int RW = cau_pkg::REM_W;
	localparam int MW = VW + FRAC_BITS;
	localparam int CW = (MW > RW + 1) ? MW : RW + 1;

	assign busy = 1'b0;

	// stage 1: products and add/sub
	logic               vld_s1;
	logic [1:0]         op_s1;
	logic signed [16:0] add_r_s1, add_i_s1;
	logic signed [31:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic [31:0]        bb_r_s1, bb_i_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		op_s1    <= opcode;
		add_r_s1 <= (opcode == cau_pkg::OP_SUB) ? 17'(a_real) - 17'(b_real)
		                                        : 17'(a_real) + 17'(b_real);
		add_i_s1 <= (opcode == cau_pkg::OP_SUB) ? 17'(a_imag) - 17'(b_imag)
		                                        : 17'(a_imag) + 17'(b_imag);
		p_rr_s1  <= a_real * b_real;
		p_ii_s1  <= a_imag * b_imag;
		p_ri_s1  <= a_real * b_imag;
		p_ir_s1  <= a_imag * b_real;
		bb_r_s1  <= 32'(b_real * b_real);
		bb_i_s1  <= 32'(b_imag * b_imag);
	end

	// stage 2: numerators and squared magnitude
	logic                vld_s2;
	logic [1:0]          op_s2;
	logic signed [16:0]  add_r_s2, add_i_s2;
	logic signed [VW-1:0] nr_s2, ni_s2;
	logic [31:0]         den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s2    <= op_s1;
		add_r_s2 <= add_r_s1;
		add_i_s2 <= add_i_s1;
		den_s2   <= bb_r_s1 + bb_i_s1;
		if (op_s1 == cau_pkg::OP_DIV) begin
			nr_s2 <= VW'(p_rr_s1) + VW'(p_ii_s1);
			ni_s2 <= VW'(p_ir_s1) - VW'(p_ri_s1);
		end else begin
			nr_s2 <= VW'(p_rr_s1) - VW'(p_ii_s1);
			ni_s2 <= VW'(p_ri_s1) + VW'(p_ir_s1);
		end
	end

	// stage 3: scaling, magnitudes, early overflow check
	logic [VW-1:0]  abs_r, abs_i;
	logic [CW-1:0]  magw_r, magw_i, den_lim;
	logic signed [VW-1:0] bias_r, bias_i;
	cau_pkg::side_t side_d;

	always_comb begin
		abs_r   = nr_s2[VW-1] ? VW'(-nr_s2) : VW'(nr_s2);
		abs_i   = ni_s2[VW-1] ? VW'(-ni_s2) : VW'(ni_s2);
		magw_r  = CW'(abs_r) << FRAC_BITS;
		magw_i  = CW'(abs_i) << FRAC_BITS;
		den_lim = CW'(den_s2) << cau_pkg::Q_W;
		bias_r  = nr_s2[VW-1] ? VW'((64'd1 << FRAC_BITS) - 64'd1) : '0;
		bias_i  = ni_s2[VW-1] ? VW'((64'd1 << FRAC_BITS) - 64'd1) : '0;
		side_d.op     = op_s2;
		side_d.neg_r  = nr_s2[VW-1];
		side_d.neg_i  = ni_s2[VW-1];
		side_d.dz     = (den_s2 == '0);
		side_d.esat_r = (magw_r >= den_lim);
		side_d.esat_i = (magw_i >= den_lim);
		case (op_s2)
			cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
				side_d.val_r = VW'(add_r_s2);
				side_d.val_i = VW'(add_i_s2);
			end
			default: begin
				side_d.val_r = (nr_s2 + bias_r) >>> FRAC_BITS;
				side_d.val_i = (ni_s2 + bias_i) >>> FRAC_BITS;
			end
		endcase
	end

	logic           vld_s3;
	cau_pkg::side_t side_s3;
	logic [RW-1:0]  mag_r_s3, mag_i_s3;
	logic [31:0]    den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s3  <= side_d;
		mag_r_s3 <= magw_r[RW-1:0];
		mag_i_s3 <= magw_i[RW-1:0];
		den_s3   <= den_s2;
	end

	logic                    dv_vld;
	cau_pkg::side_t          dv_side;
	logic [cau_pkg::Q_W-1:0] dv_q_r, dv_q_i;

	cau_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s3),
		.in_side  (side_s3),
		.in_mag_r (mag_r_s3),
		.in_mag_i (mag_i_s3),
		.in_den   (den_s3),
		.out_vld  (dv_vld),
		.out_side (dv_side),
		.out_q_r  (dv_q_r),
		.out_q_i  (dv_q_i)
	);

	// final: sign, saturation, status
	logic signed [VW-1:0] fr, fi;
	logic                 sr, si;
	logic signed [15:0]   cr, ci;
	logic [1:0]           st_d;

	always_comb begin
		if (dv_side.op == cau_pkg::OP_DIV) begin
			fr = dv_side.neg_r ? -VW'(dv_q_r) : VW'(dv_q_r);
			fi = dv_side.neg_i ? -VW'(dv_q_i) : VW'(dv_q_i);
			if (dv_side.esat_r) fr = dv_side.neg_r ? -VW'(65536) : VW'(65536);
			if (dv_side.esat_i) fi = dv_side.neg_i ? -VW'(65536) : VW'(65536);
		end else begin
			fr = dv_side.val_r;
			fi = dv_side.val_i;
		end
		sr = (fr > VW'(32767)) || (fr < -VW'(32768));
		si = (fi > VW'(32767)) || (fi < -VW'(32768));
		cr = sr ? (fr[VW-1] ? 16'sh8000 : 16'sh7fff) : fr[15:0];
		ci = si ? (fi[VW-1] ? 16'sh8000 : 16'sh7fff) : fi[15:0];
		st_d = (sr || si) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
		if (dv_side.op == cau_pkg::OP_DIV && dv_side.dz) begin
			cr   = '0;
			ci   = '0;
			st_d = cau_pkg::ST_DZ;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		res_real <= cr;
		res_imag <= ci;
		status   <= st_d;
	end
endmodule

// ===== hdl/cau_checker.sv =====
// Port-level checks for the complex arithmetic unit, bound to the top level.
module cau_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [15:0] res_real,
	input logic signed [15:0] res_imag,
	input logic [1:0]         status
);
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 20))
		else $error("result without request");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == cau_pkg::ST_OK || status == cau_pkg::ST_SAT ||
		          status == cau_pkg::ST_DZ))
		else $error("bad status");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == cau_pkg::ST_DZ) |-> (res_real == 16'sd0 && res_imag == 16'sd0))
		else $error("divide by zero result not zero");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == cau_pkg::ST_SAT) |->
		(res_real == 16'sh7fff || res_real == 16'sh8000 ||
		 res_imag == 16'sh7fff || res_imag == 16'sh8000))
		else $error("saturation without bound");
endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.res_real (res_real),
	.res_imag (res_imag),
	.status   (status)
);
